/* design/assert_macros.svh */
// Assertion macros shared by the pricer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MCP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pricer assertion failed");

// Next-cycle implication, disabled in reset.
`define MCP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pricer assertion failed");

`endif

/* design/mcp_pkg.sv */
// Shared types, constants and functions of the call pricer.
package mcp_pkg;

    localparam int COUNT_BITS = 32;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

    localparam logic [30:0] L2E_Q30 = 31'd1549082005;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [3:0]  HORNER_TERMS = 4'd12;

    typedef enum logic [2:0] {
        CFG_SPOT      = 3'd0,
        CFG_STRIKE    = 3'd1,
        CFG_DRIFT     = 3'd2,
        CFG_DIFFUSION = 3'd3,
        CFG_DISCOUNT  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] spot;
        logic [15:0] strike;
        logic [15:0] drift;
        logic [14:0] diffusion;
        logic [15:0] discount;
    } cfg_t;

    typedef struct packed {
        logic        last;
        logic [31:0] payoff;
    } q_entry_t;

    typedef enum logic [2:0] {
        F_IDLE, F_LOGRET, F_LOG2, F_FRAC, F_HMUL, F_HDIV, F_PRICE, F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE, B_DIV, B_MUL, B_FIN
    } back_state_t;

    // ceil(2^35/n): exact floor division of a 31-bit value by n = 1..12
    function automatic logic [35:0] recip(input logic [3:0] n);
        logic [35:0] r;
        case (n)
            4'd2:    r = 36'd17179869184;
            4'd3:    r = 36'd11453246123;
            4'd4:    r = 36'd8589934592;
            4'd5:    r = 36'd6871947674;
            4'd6:    r = 36'd5726623062;
            4'd7:    r = 36'd4908534053;
            4'd8:    r = 36'd4294967296;
            4'd9:    r = 36'd3817748708;
            4'd10:   r = 36'd3435973837;
            4'd11:   r = 36'd3123612579;
            4'd12:   r = 36'd2863311531;
            default: r = 36'd34359738368;
        endcase
        return r;
    endfunction

endpackage

/* design/monte_carlo_call_pricer.sv */
// Top level of the Monte Carlo European call pricer.
//
// Usage: standard-normal samples (signed Q3.12) arrive as stream
// transactions on s_tdata; s_tlast marks the final sample of a batch.
// Each sample is turned into a terminal price and a call payoff by the
// front end, which runs the exponential as a 12-term Horner evaluation; a
// sample occupies the front end until its payoff is pushed, so a new
// transaction is taken only after that. Payoffs pass through a four-entry
// queue to the back end, which adds each to the batch sum. On the last sample
// a restoring divider forms sum/count, then the B_MUL and B_FIN states apply the
// discount; the result transaction (value, sample count, overflow flag)
// is registered in B_FIN once the output register is free.
// A held result stalls only the back end; the front keeps taking samples
// until the queue fills. Reset clears the batch sums and loads the default
// configuration. Write registers through cfg_we/cfg_index/cfg_data only
// while no batch is in flight.
module monte_carlo_call_pricer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] normal_sample
    input  logic        s_tlast,   // is_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // [31:0] option_value, [63:32] sample_total,
                                   // [64] sum_overflowed
);

`include "assert_macros.svh"

    mcp_pkg::cfg_t     cfg_reg;
    logic              q_push, q_full, q_pop, q_empty;
    mcp_pkg::q_entry_t push_entry, pop_entry;

    // register file: indexes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.spot      <= 16'd100;
            cfg_reg.strike    <= 16'd110;
            cfg_reg.drift     <= 16'd164;
            cfg_reg.diffusion <= 15'd3277;
            cfg_reg.discount  <= 16'd61719;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mcp_pkg::CFG_SPOT:      cfg_reg.spot      <= cfg_data;
                mcp_pkg::CFG_STRIKE:    cfg_reg.strike    <= cfg_data;
                mcp_pkg::CFG_DRIFT:     cfg_reg.drift     <= cfg_data;
                mcp_pkg::CFG_DIFFUSION: cfg_reg.diffusion <= cfg_data[14:0];
                mcp_pkg::CFG_DISCOUNT:  cfg_reg.discount  <= cfg_data;
                default: ;
            endcase
        end
    end

    // front end: sample to payoff
    mcp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (q_push),
        .q_entry  (push_entry),
        .q_full   (q_full)
    );

    // decoupling queue
    mcp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    // back end: accumulate, divide, discount, hold the result
    mcp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `MCP_ASSERT_IMP(a_no_overflow_push, clk, rst_n, q_push, !q_full)
    `MCP_ASSERT_IMP(a_no_empty_pop, clk, rst_n, q_pop, !q_empty)
    `MCP_ASSERT_IMP(a_count_nonzero, clk, rst_n, m_tvalid, m_tdata[63:32] != 32'd0)
    `MCP_ASSERT_NXT(a_front_busy, clk, rst_n, s_tvalid && s_tready, !s_tready)

endmodule

/* design/mcp_front.sv */
// Front end: accepts samples and turns each into a call payoff.
module mcp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  mcp_pkg::cfg_t     cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,
    input  logic              s_tlast,
    output logic              q_push,
    output mcp_pkg::q_entry_t q_entry,
    input  logic              q_full
);

    mcp_pkg::front_state_t state_reg, state_next;

    logic signed [15:0] z_reg;
    logic               last_reg;
    logic signed [29:0] x_reg;
    logic [4:0]         ip_reg;
    logic [31:0]        f_reg;
    logic [29:0]        g_reg;
    logic [30:0]        m_reg;
    logic [30:0]        t_reg;
    logic [3:0]         n_reg;
    logic [46:0]        prod_reg;

    logic signed [31:0] xs;
    logic signed [61:0] p;
    logic [61:0]        pb;
    logic [63:0]        fl;
    logic [60:0]        mg;
    logic [66:0]        tq;
    logic [4:0]         sh;
    logic [46:0]        shifted;
    logic [31:0]        price;
    logic [31:0]        k16;

    always_comb
    begin
        xs = 32'(z_reg) * $signed({17'b0, cfg.diffusion})
             + ($signed(32'(signed'(cfg.drift))) <<< 12);
        p  = 62'(x_reg) * $signed({31'b0, mcp_pkg::L2E_Q30});
        pb = 62'(p) + (62'd1 << 60);
        fl = 64'(f_reg) * 64'(mcp_pkg::LN2_Q32);
        mg = 61'(m_reg) * 61'(g_reg);
        tq = 67'(t_reg) * 67'(mcp_pkg::recip(n_reg));
        sh = 5'd30 - ip_reg;
        shifted = prod_reg >> sh;
        price = (|shifted[46:32]) ? 32'hFFFF_FFFF : shifted[31:0];
        k16 = {cfg.strike, 16'b0};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mcp_pkg::F_IDLE:   if (s_tvalid) state_next = mcp_pkg::F_LOGRET;
            mcp_pkg::F_LOGRET: state_next = mcp_pkg::F_LOG2;
            mcp_pkg::F_LOG2:   state_next = mcp_pkg::F_FRAC;
            mcp_pkg::F_FRAC:   state_next = mcp_pkg::F_HMUL;
            mcp_pkg::F_HMUL:   state_next = mcp_pkg::F_HDIV;
            mcp_pkg::F_HDIV:   state_next = (n_reg == 4'd1) ? mcp_pkg::F_PRICE
                                                            : mcp_pkg::F_HMUL;
            mcp_pkg::F_PRICE:  state_next = mcp_pkg::F_PUSH;
            mcp_pkg::F_PUSH:   if (!q_full) state_next = mcp_pkg::F_IDLE;
            default:           state_next = mcp_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        q_push   = 1'b0;
        case (state_reg)
            mcp_pkg::F_IDLE: s_tready = 1'b1;
            mcp_pkg::F_PUSH: q_push = !q_full;
            default:
            begin
                s_tready = 1'b0;
                q_push   = 1'b0;
            end
        endcase
        q_entry.last   = last_reg;
        q_entry.payoff = (price > k16) ? price - k16 : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= mcp_pkg::F_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mcp_pkg::F_IDLE:
            begin
                z_reg    <= s_tdata;
                last_reg <= s_tlast;
            end
            mcp_pkg::F_LOGRET:
            begin
                // clamp the log-return to [-8, 8)
                if (xs < -(32'sd1 <<< 29))
                    x_reg <= -(30'sd1 <<< 29);
                else if (xs > (32'sd1 <<< 29) - 32'sd1)
                    x_reg <= 30'sh1FFF_FFFF;
                else
                    x_reg <= xs[29:0];
            end
            mcp_pkg::F_LOG2:
            begin
                ip_reg <= pb[60:56];
                f_reg  <= pb[55:24];
            end
            mcp_pkg::F_FRAC:
            begin
                g_reg <= fl[63:34];
                m_reg <= mcp_pkg::ONE_Q30;
                n_reg <= mcp_pkg::HORNER_TERMS;
            end
            mcp_pkg::F_HMUL: t_reg <= mg[60:30];
            mcp_pkg::F_HDIV:
            begin
                m_reg <= mcp_pkg::ONE_Q30 + tq[65:35];
                n_reg <= n_reg - 4'd1;
            end
            mcp_pkg::F_PRICE: prod_reg <= 47'(cfg.spot) * 47'(m_reg);
            default: ;
        endcase
    end

endmodule

/* design/mcp_queue.sv */
// Short payoff queue between the front and back ends.
module mcp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  mcp_pkg::q_entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output mcp_pkg::q_entry_t pop_entry,
    output logic              empty
);

    mcp_pkg::q_entry_t                  mem_reg [mcp_pkg::Q_DEPTH];
    logic [mcp_pkg::Q_PTR_BITS-1:0]     wr_reg, rd_reg;
    logic [mcp_pkg::Q_PTR_BITS:0]       cnt_reg;

    assign full      = (cnt_reg == (mcp_pkg::Q_PTR_BITS+1)'(mcp_pkg::Q_DEPTH));
    assign empty     = (cnt_reg == '0);
    assign pop_entry = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            if (push && !pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_entry;
    end

endmodule

/* design/mcp_back.sv */
// Back end: accumulates payoffs and forms the discounted batch mean.
module mcp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  mcp_pkg::cfg_t     cfg,
    input  logic              q_empty,
    input  mcp_pkg::q_entry_t q_entry,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [71:0]       m_tdata
);

    localparam int CB = mcp_pkg::COUNT_BITS;

    mcp_pkg::back_state_t state_reg, state_next;

    logic [63:0]   sum_reg;
    logic [CB-1:0] count_reg;
    logic          ovf_reg;
    logic [63:0]   quo_reg;
    logic [CB:0]   rem_reg;
    logic [5:0]    bit_reg;
    logic [63:0]   hi_reg;
    logic [15:0]   lo_reg;
    logic          out_valid_reg;
    logic [71:0]   out_data_reg;

    logic [64:0]   sum_ext;
    logic [CB:0]   rem_sh;
    logic          take;
    logic          load_out;
    logic [33:0]   v_add;
    logic [31:0]   value;

    always_comb
    begin
        sum_ext = {1'b0, sum_reg} + 65'(q_entry.payoff);
        rem_sh  = {rem_reg[CB-1:0], quo_reg[63]};
        take    = (rem_sh >= {1'b0, count_reg});
        v_add   = 34'(hi_reg[31:0]) + 34'(lo_reg);
        if (|hi_reg[63:32] || |v_add[33:32])
            value = 32'hFFFF_FFFF;
        else
            value = v_add[31:0];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mcp_pkg::B_IDLE:
                if (!q_empty && q_entry.last) state_next = mcp_pkg::B_DIV;
            mcp_pkg::B_DIV:
                if (bit_reg == 6'd63) state_next = mcp_pkg::B_MUL;
            mcp_pkg::B_MUL: state_next = mcp_pkg::B_FIN;
            mcp_pkg::B_FIN:
                if (!out_valid_reg || m_tready) state_next = mcp_pkg::B_IDLE;
            default: state_next = mcp_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            mcp_pkg::B_IDLE: q_pop = !q_empty;
            mcp_pkg::B_FIN:  load_out = !out_valid_reg || m_tready;
            default:
            begin
                q_pop    = 1'b0;
                load_out = 1'b0;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mcp_pkg::B_IDLE;
            sum_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                if (sum_ext[64])
                begin
                    sum_reg <= '1;
                    ovf_reg <= 1'b1;
                end
                else
                    sum_reg <= sum_ext[63:0];
                if (count_reg != '1)
                    count_reg <= count_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                sum_reg       <= '0;
                count_reg     <= '0;
                ovf_reg       <= 1'b0;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mcp_pkg::B_IDLE:
            begin
                // sum after this payoff is applied
                quo_reg <= sum_ext[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_ext[63:0];
                rem_reg <= '0;
                bit_reg <= '0;
            end
            mcp_pkg::B_DIV:
            begin
                rem_reg <= take ? rem_sh - {1'b0, count_reg} : rem_sh;
                quo_reg <= {quo_reg[62:0], take};
                bit_reg <= bit_reg + 1'b1;
            end
            mcp_pkg::B_MUL:
            begin
                hi_reg <= 64'(quo_reg[63:16]) * 64'(cfg.discount);
                lo_reg <= 16'((32'(quo_reg[15:0]) * 32'(cfg.discount)) >> 16);
            end
            default: ;
        endcase
        if (load_out)
            out_data_reg <= {7'b0, ovf_reg, 32'(count_reg), value};
    end

endmodule

/* bench/monte_carlo_call_pricer_tb.sv */
// Self-checking bench for the Monte Carlo call pricer: directed and random batches.
module monte_carlo_call_pricer_tb;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int DRAIN_CYCLES = 160;   // idle time after the last expected result has arrived

    typedef struct {
        bit [31:0] option_value;
        bit [31:0] sample_total;
        bit        sum_overflowed;
    } batch_result_t;

    // Holds its own copy of the pricer state and the expected batch results.
    class batch_scoreboard;
        bit [15:0]        spot;
        bit [15:0]        strike;
        bit signed [15:0] drift;
        bit [14:0]        diffusion;
        bit [15:0]        discount;
        bit [63:0]        payoff_sum;
        bit [31:0]        sample_count;
        bit               overflow_seen;
        batch_result_t    pending_results[$];
        int               errors;
        int               results_seen;
        int               samples_seen;

        function new();
            spot = 100;
            strike = 110;
            drift = 164;
            diffusion = 3277;
            discount = 61719;
            payoff_sum = 0;
            sample_count = 0;
            overflow_seen = 0;
            errors = 0;
            results_seen = 0;
            samples_seen = 0;
        endfunction

        function void write_reg(mcp_pkg::cfg_index_t idx, bit [15:0] value);
            case (idx)
                mcp_pkg::CFG_SPOT:      spot = value;
                mcp_pkg::CFG_STRIKE:    strike = value;
                mcp_pkg::CFG_DRIFT:     drift = value;
                mcp_pkg::CFG_DIFFUSION: diffusion = value[14:0];
                mcp_pkg::CFG_DISCOUNT:  discount = value;
                default: ;
            endcase
        endfunction

        // Terminal price in Q16.16 from one Q3.12 sample.
        function bit [63:0] terminal_price(bit signed [15:0] z);
            longint    x;
            longint    p;
            bit [63:0] yq;
            bit [63:0] frac;
            bit [63:0] g;
            bit [63:0] m;
            bit [63:0] price;
            int        ip;
            x = longint'(z) * longint'(diffusion) + longint'(drift) * 4096;
            if (x < -(longint'(1) << 29))
                x = -(longint'(1) << 29);
            if (x > (longint'(1) << 29) - 1)
                x = (longint'(1) << 29) - 1;
            p = x * longint'(1549082005);
            yq = 64'(p + (longint'(1) << 60)) >> 24;
            ip = int'(yq >> 32) - 16;
            frac = {32'd0, yq[31:0]};
            g = (frac * 64'd2977044472) >> 34;
            m = 64'd1 << 30;
            for (int n = 12; n >= 1; n--)
                m = (64'd1 << 30) + ((m * g) >> 30) / 64'(n);
            price = (64'(spot) * m) >> (14 - ip);
            return (price > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : price;
        endfunction

        function void note_sample(bit [15:0] z, bit last);
            bit [63:0]     price;
            bit [63:0]     k16;
            bit [63:0]     payoff;
            bit [63:0]     mean;
            bit [63:0]     v;
            batch_result_t r;
            samples_seen++;
            price = terminal_price(z);
            k16 = 64'(strike) << 16;
            payoff = (price > k16) ? price - k16 : 64'd0;
            if (payoff_sum > ~payoff) begin
                payoff_sum = '1;
                overflow_seen = 1;
            end
            else
                payoff_sum += payoff;
            if (sample_count != '1)
                sample_count++;
            if (!last)
                return;
            mean = payoff_sum / 64'(sample_count);
            v = (mean >> 16) * 64'(discount);
            if (v <= 64'hFFFF_FFFF) begin
                v += ((mean & 64'hFFFF) * 64'(discount)) >> 16;
                if (v > 64'hFFFF_FFFF)
                    v = 64'hFFFF_FFFF;
            end
            else
                v = 64'hFFFF_FFFF;
            r.option_value = v[31:0];
            r.sample_total = sample_count;
            r.sum_overflowed = overflow_seen;
            pending_results.push_back(r);
            payoff_sum = 0;
            sample_count = 0;
            overflow_seen = 0;
        endfunction

        function void check_result(bit [71:0] data);
            batch_result_t e;
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, data);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (data[31:0] !== e.option_value) begin
                $display("%0t: option_value expected %h actual %h", $time,
                         e.option_value, data[31:0]);
                errors++;
            end
            if (data[63:32] !== e.sample_total) begin
                $display("%0t: sample_total expected %0d actual %0d", $time,
                         e.sample_total, data[63:32]);
                errors++;
            end
            if (data[64] !== e.sum_overflowed) begin
                $display("%0t: sum_overflowed expected %b actual %b", $time,
                         e.sum_overflowed, data[64]);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = mcp_pkg::CFG_SPOT;
    logic [15:0] cfg_data = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = 0;   // [15:0] normal_sample
    logic        s_tlast = 0;   // is_last
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [71:0] m_tdata;       // [31:0] option_value, [63:32] sample_total,
                                // [64] sum_overflowed

    // Idle percentages of the sender and the receiver for the current phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;
    int batches_sent = 0;

    batch_scoreboard sb = new();

    monte_carlo_call_pricer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Watchdog: abandon the run if it hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: check each result transaction, then choose ready for the next edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Write all five registers back to back; the block must be idle.
    task automatic load_config(bit [15:0] spot, bit [15:0] strike, bit [15:0] drift,
                               bit [15:0] diffusion, bit [15:0] discount);
        bit [15:0] values[5];
        values = '{spot, strike, drift, diffusion, discount};
        for (int i = 0; i < 5; i++) begin
            cfg_we <= 1;
            cfg_index <= mcp_pkg::cfg_index_t'(i);
            cfg_data <= values[i];
            sb.write_reg(mcp_pkg::cfg_index_t'(i), values[i]);
            @(posedge clk);
        end
        cfg_we <= 0;
    endtask

    // Offer one sample and hold it until taken; then idle at random.
    task automatic send_sample(bit [15:0] z, bit last);
        s_tdata <= z;
        s_tlast <= last;
        s_tvalid <= 1;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_sample(z, last);
        if (last)
            batches_sent++;
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Drop valid, wait for every expected result, then let the back end settle.
    task automatic drain();
        s_tvalid <= 0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Mostly near-normal samples, with full-range ones to reach every bit.
    function automatic bit [15:0] random_sample();
        if ($urandom_range(3) == 0)
            return 16'($urandom_range(65535));
        return 16'($signed($urandom_range(24576)) - 12288);
    endfunction

    // One random batch: mostly short, sometimes long.
    task automatic send_batch();
        int len;
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6);
        for (int i = 0; i < len; i++)
            send_sample(random_sample(), i == len - 1);
    endtask

    initial
    begin
        int sent;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: default registers, extremes of the sample, single-sample batches and a three-sample batch.
        send_sample(16'h8000, 1);
        send_sample(16'h7FFF, 1);
        send_sample(16'h0000, 1);
        send_sample(16'h1000, 0);
        send_sample(16'hF000, 0);
        send_sample(16'h2000, 1);
        drain();

        // Largest spot, zero strike, full diffusion: log-return saturates both ways
        // and the price clips at the Q16.16 maximum.
        load_config(16'hFFFF, 16'h0000, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_sample(16'h7FFF, 1);
        send_sample(16'h8000, 1);
        send_sample(16'h7FFF, 0);
        send_sample(16'h7FFF, 0);
        send_sample(16'h0000, 1);
        drain();

        // Zero spot, most negative drift, zero discount and zero diffusion.
        load_config(16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'h0000);
        send_sample(16'h1234, 1);
        drain();
        load_config(16'd200, 16'd100, 16'h8000, 16'h0000, 16'hFFFF);
        send_sample(16'h7FFF, 0);
        send_sample(16'h0001, 1);
        drain();
        load_config(16'd90, 16'd100, 16'd164, 16'd3277, 16'd61719);
        for (int i = 0; i < 6; i++)
            send_sample(random_sample(), i == 5);
        drain();

        // Random phases cycle four idle patterns; phases 1-6 load random registers, phase 7 the extreme set.
        sent = sb.samples_seen;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 10; recv_stall_pct = 10; end
            endcase
            if (phase == 7)
                load_config(16'hFFFF, 16'h0000, 16'h7FFF, 16'h7FFF, 16'hFFFF);
            else if (phase > 0)
                load_config(16'($urandom_range(40, 400)), 16'($urandom_range(40, 400)),
                            16'($signed($urandom_range(4000)) - 2000),
                            16'($urandom_range(800, 8000)), 16'($urandom_range(50000, 65535)));
            while (sb.samples_seen - sent < 105 * (phase + 1)) begin
                send_batch();
                // In phase 2, hold off after every tenth batch until everything owed has arrived.
                if (phase == 2 && batches_sent % 10 == 0) begin
                    s_tvalid <= 0;
                    @(posedge clk);
                    while (sb.pending_results.size() != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        $display("Covered %0d samples in %0d batches, %0d results checked, over 8 idle phases",
                 sb.samples_seen, batches_sent, sb.results_seen);
        $display("Configurations included full-range spot, strike, drift, diffusion, discount");
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
